// ===== src/bbc_pkg.sv =====
// Shared types and constants for the Bollinger band calculator.
// No dependencies; imported by the top level.
package bbc_pkg;

    localparam int PRICE_W   = 24;   // input sample width
    localparam int WIN_W     = 7;    // window length register width
    localparam int FACTOR_W  = 12;   // band width factor register width
    localparam int BAND_W    = 32;   // output band width
    localparam int FRAC_BITS = 8;    // fraction bits of the factor

    localparam logic [WIN_W-1:0]    WIN_RESET    = 7'd20;
    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 12'd512;
    localparam logic [WIN_W-1:0]    WIN_MIN      = 7'd2;

    // register indexes on the configuration port
    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_FACTOR = 1'b1;

    typedef logic [PRICE_W-1:0] price_t;
    typedef logic [BAND_W-1:0]  band_t;

endpackage

// ===== src/bollinger_band_calculator_unit.sv =====
// Bollinger band calculator, top level: sequencer, window rings, config port.
// Depends on bbc_pkg, bbc_ram, bbc_div and bbc_isqrt.
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+--------------------------
//   input     | in_valid / in_ready        | price
//   output    | out_valid / out_ready      | upper_band, lower_band
//   config    | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// A word runs through two bit-serial divisions by the window length and a
// two-bit-per-cycle square root; warm-up words skip the second division and
// the root. The sequencer takes no new word until it has finished the last.
// Reset clears all control state; ring entries carry valid bits, so no
// clearing pass is needed. A write of window_length restarts the warm-up.
// A new word is taken while a result still waits in the output register;
// a stalled output holds the sequencer in its final step.
module bollinger_band_calculator_unit
    import bbc_pkg::*;
#(
    parameter int MAX_WINDOW = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // input words
    input  logic        in_valid,
    output logic        in_ready,
    input  price_t      price,
    // result words
    output logic        out_valid,
    input  logic        out_ready,
    output band_t       upper_band,
    output band_t       lower_band,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PW   = $clog2(MAX_WINDOW);          // ring pointer
    localparam int LW   = $clog2(MAX_WINDOW + 1);      // window length
    localparam int SEW  = $clog2(2 * MAX_WINDOW + 1);  // samples seen
    localparam int SW   = PRICE_W + PW;                // sample sum
    localparam int SQ_W = 2 * PRICE_W;                 // squared residual
    localparam int SQW  = SQ_W + PW;                   // square sum
    localparam int DW   = (SQW + SQW % 2) / 2;         // deviation
    localparam int PRW  = FACTOR_W + DW;               // factor product
    localparam int EXT  = PRW + 2;                     // band arithmetic

    localparam logic [SEW-1:0] SEEN_CAP = SEW'(2 * MAX_WINDOW);
    localparam logic signed [EXT-1:0] SAT_HI = EXT'(64'sh7FFF_FFFF);
    localparam logic signed [EXT-1:0] SAT_LO = EXT'(-64'sh8000_0000);

    // sequencer states
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_READ      = 4'd1;
    localparam logic [3:0] S_ADD       = 4'd2;
    localparam logic [3:0] S_DIVA_GO   = 4'd3;
    localparam logic [3:0] S_DIVA_WAIT = 4'd4;
    localparam logic [3:0] S_SQUARE    = 4'd5;
    localparam logic [3:0] S_ACC       = 4'd6;
    localparam logic [3:0] S_DIVB_GO   = 4'd7;
    localparam logic [3:0] S_DIVB_WAIT = 4'd8;
    localparam logic [3:0] S_ROOT_GO   = 4'd9;
    localparam logic [3:0] S_ROOT_WAIT = 4'd10;
    localparam logic [3:0] S_SCALE     = 4'd11;
    localparam logic [3:0] S_EMIT      = 4'd12;

    // configuration registers
    logic [WIN_W-1:0]    win_reg;
    logic [FACTOR_W-1:0] factor_reg;
    logic                cfg_wr;
    logic                win_clear;

    // control state
    logic [3:0]          state_reg, state_next;
    logic [PW-1:0]       wp_reg;
    logic [SEW-1:0]      seen_reg;
    logic [MAX_WINDOW-1:0] valid_reg;
    logic                out_valid_reg;

    // datapath registers
    price_t              price_reg;
    logic [SW-1:0]       ssum_reg;
    logic [SQW-1:0]      qsum_reg;
    logic [SQ_W-1:0]     old_sq_reg;
    price_t              avg_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [SQW-1:0]      mean_reg;
    logic [DW-1:0]       dev_reg;
    logic [PRW-1:0]      prod_reg;
    band_t               upper_reg, lower_reg;

    // window and pointer arithmetic
    logic [LW-1:0]       win_len;
    logic [PW:0]         old_wide;
    logic [PW-1:0]       old_idx;
    logic [PW-1:0]       wp_inc;
    logic                old_valid;

    // ring ports
    price_t              samp_rdata;
    logic [SQ_W-1:0]     sq_rdata;
    price_t              old_samp;

    // shared units
    logic                div_start, div_done;
    logic [SQW-1:0]      div_dividend, div_quotient;
    logic                root_start, root_done;
    logic [DW-1:0]       root_val;

    // residual and band math
    logic signed [PRICE_W:0]     resid;
    logic signed [2*PRICE_W+1:0] resid_sq;
    logic signed [EXT-1:0]       avg_x, scaled_x, up_x, lo_x;
    logic                        out_free;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign win_clear = cfg_wr && (paddr[2] == REG_WINDOW);
    assign prdata    = (paddr[2] == REG_WINDOW) ? 32'(win_reg) : 32'(factor_reg);

    // clamp the window length into 2..MAX_WINDOW
    always_comb
    begin
        if (win_reg < WIN_MIN)
        begin
            win_len = LW'(2);
        end
        else if (32'(win_reg) > 32'(MAX_WINDOW))
        begin
            win_len = LW'(MAX_WINDOW);
        end
        else
        begin
            win_len = LW'(win_reg);
        end
    end

    // entry leaving the window, modulo the ring depth
    always_comb
    begin
        if ({1'b0, wp_reg} >= (PW+1)'(win_len))
        begin
            old_wide = {1'b0, wp_reg} - (PW+1)'(win_len);
        end
        else
        begin
            old_wide = {1'b0, wp_reg} + (PW+1)'(MAX_WINDOW) - (PW+1)'(win_len);
        end
    end

    assign old_idx   = old_wide[PW-1:0];
    assign wp_inc    = (wp_reg == PW'(MAX_WINDOW - 1)) ? '0 : wp_reg + PW'(1);
    assign old_valid = valid_reg[old_idx];
    assign old_samp  = old_valid ? samp_rdata : '0;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || out_ready;

    bbc_ram #(
        .WIDTH (PRICE_W),
        .DEPTH (MAX_WINDOW)
    ) u_sample_ring (
        .clk   (clk),
        .we    (state_reg == S_ADD),
        .waddr (wp_reg),
        .wdata (price_reg),
        .raddr (old_idx),
        .rdata (samp_rdata)
    );

    bbc_ram #(
        .WIDTH (SQ_W),
        .DEPTH (MAX_WINDOW)
    ) u_square_ring (
        .clk   (clk),
        .we    (state_reg == S_ACC),
        .waddr (wp_reg),
        .wdata (sq_reg),
        .raddr (old_idx),
        .rdata (sq_rdata)
    );

    assign div_start    = (state_reg == S_DIVA_GO) || (state_reg == S_DIVB_GO);
    assign div_dividend = (state_reg == S_DIVA_GO) ? SQW'(ssum_reg) : qsum_reg;

    bbc_div #(
        .WIDTH (SQW),
        .DW    (LW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (win_len),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign root_start = (state_reg == S_ROOT_GO);

    bbc_isqrt #(
        .WIDTH (SQW)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (mean_reg),
        .done     (root_done),
        .root     (root_val)
    );

    // residual of this sample against its own window average
    assign resid    = $signed({1'b0, price_reg}) - $signed({1'b0, avg_reg});
    assign resid_sq = resid * resid;

    // bands: average plus and minus the scaled deviation, saturated
    assign avg_x    = $signed(EXT'(avg_reg));
    assign scaled_x = $signed(EXT'(prod_reg >> FRAC_BITS));
    assign up_x     = avg_x + scaled_x;
    assign lo_x     = avg_x - scaled_x;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (in_valid) state_next = S_READ;
            S_READ:      state_next = S_ADD;
            S_ADD:       state_next = S_DIVA_GO;
            S_DIVA_GO:   state_next = S_DIVA_WAIT;
            S_DIVA_WAIT: if (div_done) state_next = S_SQUARE;
            S_SQUARE:    state_next = S_ACC;
            S_ACC:
            begin
                if (seen_reg >= SEW'({win_len, 1'b0}))
                begin
                    state_next = S_DIVB_GO;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIVB_GO:   state_next = S_DIVB_WAIT;
            S_DIVB_WAIT: if (div_done) state_next = S_ROOT_GO;
            S_ROOT_GO:   state_next = S_ROOT_WAIT;
            S_ROOT_WAIT: if (root_done) state_next = S_SCALE;
            S_SCALE:     state_next = S_EMIT;
            S_EMIT:      if (out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            win_reg       <= WIN_RESET;
            factor_reg    <= FACTOR_RESET;
            wp_reg        <= '0;
            seen_reg      <= '0;
            valid_reg     <= '0;
            ssum_reg      <= '0;
            qsum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end

            if (cfg_wr && paddr[2] == REG_FACTOR)
            begin
                factor_reg <= pwdata[FACTOR_W-1:0];
            end

            if (win_clear)
            begin
                // drop the window contents and restart the warm-up
                win_reg   <= pwdata[WIN_W-1:0];
                wp_reg    <= '0;
                seen_reg  <= '0;
                valid_reg <= '0;
                ssum_reg  <= '0;
                qsum_reg  <= '0;
            end
            else
            begin
                if (state_reg == S_ADD)
                begin
                    ssum_reg <= ssum_reg + SW'(price_reg) - SW'(old_samp);
                    if (seen_reg < SEEN_CAP)
                    begin
                        seen_reg <= seen_reg + SEW'(1);
                    end
                end
                if (state_reg == S_ACC)
                begin
                    qsum_reg          <= qsum_reg + SQW'(sq_reg) - SQW'(old_sq_reg);
                    valid_reg[wp_reg] <= 1'b1;
                    wp_reg            <= wp_inc;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            price_reg <= price;
        end
        if (state_reg == S_ADD)
        begin
            // hold the leaving square before the ring can change
            old_sq_reg <= old_valid ? sq_rdata : '0;
        end
        if (state_reg == S_DIVA_WAIT && div_done)
        begin
            avg_reg <= div_quotient[PRICE_W-1:0];
        end
        if (state_reg == S_SQUARE)
        begin
            sq_reg <= (seen_reg >= SEW'(win_len)) ? resid_sq[SQ_W-1:0] : '0;
        end
        if (state_reg == S_DIVB_WAIT && div_done)
        begin
            mean_reg <= div_quotient;
        end
        if (state_reg == S_ROOT_WAIT && root_done)
        begin
            dev_reg <= root_val;
        end
        if (state_reg == S_SCALE)
        begin
            prod_reg <= PRW'(factor_reg) * PRW'(dev_reg);
        end
        if (state_reg == S_EMIT && out_free)
        begin
            upper_reg <= (up_x > SAT_HI) ? BAND_W'(SAT_HI) : BAND_W'(up_x);
            lower_reg <= (lo_x < SAT_LO) ? BAND_W'(SAT_LO) : BAND_W'(lo_x);
        end
    end

    assign out_valid  = out_valid_reg;
    assign upper_band = upper_reg;
    assign lower_band = lower_reg;

    a_div_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIVA_WAIT || state_reg == S_DIVB_WAIT))
        else $error("divider finished outside a wait step");

    a_root_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        root_done |-> (state_reg == S_ROOT_WAIT))
        else $error("square root finished outside its wait step");

    a_seen_capped: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= SEEN_CAP)
        else $error("sample count passed its cap");

    a_emit_after_warmup: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (seen_reg >= SEW'({win_len, 1'b0})))
        else $error("band emitted during warm-up");

    a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free) |=> out_valid_reg)
        else $error("emitted band not presented");

endmodule

// ===== src/bbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bbc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/bbc_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// No dependencies.
module bbc_div #(
    parameter int WIDTH = 54,
    parameter int DW    = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [DW-1:0]    divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] quo_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    dsr_reg;
    logic [CW-1:0]    cnt_reg;
    logic             done_reg;
    logic [DW:0]      trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[WIDTH-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CW'(WIDTH);
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CW'(1));
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            // shift in one dividend bit, subtract when it fits
            rem_reg <= fits ? DW'(trial - {1'b0, dsr_reg}) : trial[DW-1:0];
            quo_reg <= {quo_reg[WIDTH-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/bbc_isqrt.sv =====
// Digit-serial integer square root: two radicand bits per cycle.
// No dependencies.
module bbc_isqrt #(
    parameter int WIDTH = 54
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [WIDTH-1:0]                   radicand,
    output logic                               done,
    output logic [(WIDTH + WIDTH % 2)/2-1:0]   root
);

    localparam int IW = WIDTH + WIDTH % 2;
    localparam int RW = IW / 2;
    localparam int CW = $clog2(RW + 1);

    logic [IW-1:0]   val_reg;
    logic [RW+1:0]   rem_reg;
    logic [RW-1:0]   root_reg;
    logic [CW-1:0]   cnt_reg;
    logic            done_reg;
    logic [RW+3:0]   shifted;
    logic [RW+3:0]   test;
    logic            fits;

    assign shifted = {rem_reg, val_reg[IW-1:IW-2]};
    assign test    = {2'b00, root_reg, 2'b01};
    assign fits    = (shifted >= test);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CW'(RW);
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CW'(1));
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= IW'(radicand);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            val_reg  <= {val_reg[IW-3:0], 2'b00};
            rem_reg  <= fits ? (RW+2)'(shifted - test) : shifted[RW+1:0];
            root_reg <= {root_reg[RW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== sim/bollinger_band_calculator_unit_tb.sv =====
// Self-checking testbench for bollinger_band_calculator_unit: directed table and extremes, then random and pressure.
// Depends on bbc_pkg and the block's RTL; predicts bands with a local streaming model.
`timescale 1ns / 100ps

module bollinger_band_calculator_unit_tb
    import bbc_pkg::*;
();

    localparam int MAXW = 64;
    localparam logic [2:0] ADDR_WINDOW = 3'd0;   // register index 0 at byte 0
    localparam logic [2:0] ADDR_FACTOR = 3'd4;   // register index 1 at byte 4
    localparam longint CYCLE_LIMIT = 3_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    price_t      price = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    band_t       upper_band;
    band_t       lower_band;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    bollinger_band_calculator_unit dut (.*);

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Band predictor: own copy of the window state and registers
    // ---------------------------------------------------------------
    logic [WIN_W-1:0]    win_reg;
    logic [FACTOR_W-1:0] factor_reg;
    logic [23:0]         price_hist [MAXW];
    logic [47:0]         sqres_hist [MAXW];
    logic [29:0]         price_total;
    logic [53:0]         sqres_total;
    int unsigned         seen_cnt;
    int unsigned         wr_idx;

    typedef struct {
        band_t up;
        band_t dn;
    } bands_t;
    bands_t band_q[$];

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic band_t clamp32(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return band_t'(v);
    endfunction

    task automatic clear_window();
        for (int i = 0; i < MAXW; i++)
        begin
            price_hist[i] = '0;
            sqres_hist[i] = '0;
        end
        price_total = '0;
        sqres_total = '0;
        seen_cnt = 0;
        wr_idx = 0;
    endtask

    // Advance the model by one price; return 1 with bands once warm.
    function automatic bit predict_bands(price_t p, output bands_t b);
        int unsigned len;
        int unsigned old;
        longint      avg;
        longint      r;
        logic [63:0] sq;
        logic [63:0] dev;
        logic [63:0] scaled;
        len = win_reg < 2 ? 2 : (win_reg > MAXW ? MAXW : win_reg);
        old = (wr_idx + MAXW - len) % MAXW;
        price_total = price_total + p - price_hist[old];
        price_hist[wr_idx] = p;
        if (seen_cnt < 2 * MAXW) seen_cnt++;
        avg = longint'(price_total) / len;
        sq = 0;
        if (seen_cnt >= len)
        begin
            r = longint'(p) - avg;
            sq = r * r;
        end
        sqres_total = sqres_total + sq[53:0] - sqres_hist[old];
        sqres_hist[wr_idx] = sq[47:0];
        wr_idx = (wr_idx + 1) % MAXW;
        if (seen_cnt < 2 * len) return 0;
        dev = int_sqrt(64'(sqres_total) / len);
        scaled = (64'(factor_reg) * dev) >> 8;
        b.up = clamp32(avg + longint'(scaled));
        b.dn = clamp32(avg - longint'(scaled));
        return 1;
    endfunction

    // ---------------------------------------------------------------
    // Idle control shared by driver and receiver
    // ---------------------------------------------------------------
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  recv_hold = 1'b0;      // long receiver hold-off
    int  fail_cnt = 0;
    longint cycle_cnt = 0;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: drop ready at random, or hold it off during a pressure stretch.
    always @(posedge clk)
    begin
        if (!rst_n) out_ready <= 1'b0;
        else out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Checker: compare every accepted word with the oldest expectation.
    always @(posedge clk)
    begin
        bands_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (band_q.size() == 0)
            begin
                $error("unexpected result word up=%0d dn=%0d", $signed(upper_band),
                       $signed(lower_band));
                fail_cnt++;
            end
            else
            begin
                e = band_q.pop_front();
                if (upper_band !== e.up)
                begin
                    $error("upper_band expected %0d actual %0d", $signed(e.up),
                           $signed(upper_band));
                    fail_cnt++;
                end
                if (lower_band !== e.dn)
                begin
                    $error("lower_band expected %0d actual %0d", $signed(e.dn),
                           $signed(lower_band));
                    fail_cnt++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Driver tasks
    // ---------------------------------------------------------------
    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_WINDOW)
        begin
            win_reg = data[WIN_W-1:0];
            clear_window();
        end
        else if (addr == ADDR_FACTOR)
        begin
            factor_reg = data[FACTOR_W-1:0];
        end
        // leave the bus idle before the next transfer
        @(posedge clk);
    endtask

    // Offer one price, hold it until taken, then record its expectation.
    task automatic send_price(price_t p);
        bands_t b;
        if ($urandom_range(99) < send_idle_pct)
        begin
            // drop valid while the sender idles
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
        in_valid <= 1'b1;
        price <= p;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (predict_bands(p, b)) band_q.push_back(b);
        // keep valid high if another word follows right away; caller lowers it
    endtask

    task automatic idle_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every expected word is in, then let the block finish
    // words that produce no result (warm-up) before touching registers.
    task automatic drain();
        idle_input();
        while (band_q.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // Random price: mostly mid range with small spread, some extremes.
    function automatic price_t rand_price(price_t base);
        int k;
        k = $urandom_range(99);
        if (k < 8) return price_t'($urandom);
        if (k < 11) return '1;
        if (k < 14) return '0;
        return price_t'(base + $urandom_range(4095) - 2048);
    endfunction

    task automatic run_phase(int n, int idle_pct, int stall_pct);
        price_t base;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        base = price_t'($urandom);
        for (int i = 0; i < n; i++)
        begin
            send_price(rand_price(base));
            if ($urandom_range(99) < 20) idle_input();
        end
        drain();
    endtask

    // ---------------------------------------------------------------
    // Directed table: expected bands typed in where obvious
    // ---------------------------------------------------------------
    typedef struct {
        price_t p;
        bit     known;    // expected bands given in the row
        band_t  up;
        band_t  dn;
    } dir_row_t;

    initial
    begin
        dir_row_t rows[$];
        bands_t   b;
        win_reg = WIN_RESET;
        factor_reg = FACTOR_RESET;
        clear_window();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Window 2 (minimum): constant zeros, then constant max prices, then alternating extremes.
        apb_write(ADDR_WINDOW, 32'd2);
        for (int i = 0; i < 4; i++) rows.push_back('{24'd0, 1'b1, 32'd0, 32'd0});
        for (int i = 0; i < 6; i++) rows.push_back('{24'hFFFFFF, 1'b0, '0, '0});
        rows.push_back('{24'hFFFFFF, 1'b1, 32'h00FFFFFF, 32'h00FFFFFF});
        for (int i = 0; i < 8; i++) rows.push_back('{price_t'(i[0] ? 24'hFFFFFF : 0), 1'b0,
                                                    '0, '0});
        foreach (rows[i])
        begin
            send_price(rows[i].p);
            idle_input();
            if (rows[i].known && band_q.size() != 0)
            begin
                b = band_q[$];
                if (b.up !== rows[i].up)
                begin
                    $error("table row %0d: upper_band expected %0d actual %0d", i,
                           $signed(rows[i].up), $signed(b.up));
                    fail_cnt++;
                end
                if (b.dn !== rows[i].dn)
                begin
                    $error("table row %0d: lower_band expected %0d actual %0d", i,
                           $signed(rows[i].dn), $signed(b.dn));
                    fail_cnt++;
                end
            end
        end
        drain();

        // Factor extremes with the largest swing, window 0 clamps to 2.
        apb_write(ADDR_FACTOR, 32'd4095);
        apb_write(ADDR_WINDOW, 32'd0);
        for (int i = 0; i < 6; i++)
        begin
            send_price(i[0] ? 24'hFFFFFF : 24'd0);
        end
        drain();
        apb_write(ADDR_FACTOR, 32'd0);

        // Window 127 clamps to 64; factor max.
        apb_write(ADDR_WINDOW, 32'h7F);
        apb_write(ADDR_FACTOR, 32'hFFF);
        run_phase(200, 0, 0);

        // Random phases over several settings and idling mixes.
        apb_write(ADDR_WINDOW, 32'd20);
        apb_write(ADDR_FACTOR, 32'd512);
        run_phase(350, 0, 0);
        apb_write(ADDR_WINDOW, 32'd5);
        apb_write(ADDR_FACTOR, 32'd256);
        run_phase(350, 57, 0);
        apb_write(ADDR_WINDOW, 32'd3);
        apb_write(ADDR_FACTOR, 32'd1000);
        run_phase(350, 0, 57);
        apb_write(ADDR_WINDOW, 32'd64);
        apb_write(ADDR_FACTOR, 32'd2048);
        run_phase(350, 27, 27);

        // Pressure: hold the receiver off while words keep coming.
        apb_write(ADDR_WINDOW, 32'd2);
        apb_write(ADDR_FACTOR, 32'd3000);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 1'b1;
        fork
            begin
                repeat (3000) @(posedge clk);
                recv_hold = 1'b0;
            end
            for (int i = 0; i < 40; i++) send_price(rand_price(24'h800000));
        join
        drain();

        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bbc_pkg.sv
src/bbc_ram.sv
src/bbc_div.sv
src/bbc_isqrt.sv
src/bollinger_band_calculator_unit.sv
sim/bollinger_band_calculator_unit_tb.sv
